// ===== src/pct_pkg.sv =====
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants of the pair correspondence table
// Holds the table capacity, derived widths, the sequencer state type and the
// control structs that pass between the sequencer, the top level and the cells.
// ----------------------------------------------------------------------------
package pct_pkg;

  // Table geometry
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned PCNT_W   = 9;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SWEEP,
    ST_FINISH
  } pct_state_e;

  // Phase strobes from the sequencer
  typedef struct packed {
    logic capture;
    logic sweep;
    logic finish;
  } pct_phase_t;

  // Control seen by every cell
  typedef struct packed {
    logic capture;
    logic sweep;
    logic shift;
  } pct_cell_ctrl_t;

endpackage

// ===== src/pct_cell.sv =====
// ----------------------------------------------------------------------------
// pct_cell: one entry of the pair table
// Stores one pair, compares it with the broadcast query, and passes its hit
// flags toward cell zero; on append it takes the pair of its left neighbor.
// ----------------------------------------------------------------------------
module pct_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pct_pkg::pct_cell_ctrl_t       ctrl_i,
  input  logic                          valid_i,
  input  logic [pct_pkg::ID_W-1:0]      q_star_i,
  input  logic [pct_pkg::ID_W-1:0]      q_field_i,
  input  logic [pct_pkg::ID_W-1:0]      prev_star_i,
  input  logic [pct_pkg::ID_W-1:0]      prev_field_i,
  output logic [pct_pkg::ID_W-1:0]      star_o,
  output logic [pct_pkg::ID_W-1:0]      field_o,
  input  logic                          dup_i,
  input  logic                          cnf_i,
  output logic                          dup_o,
  output logic                          cnf_o
);
  import pct_pkg::*;

  logic [ID_W-1:0] star_q, field_q;
  logic            dup_q, dup_d, cnf_q, cnf_d;
  logic            ms, mf;

  // Compare stored pair with the query
  assign ms = (star_q == q_star_i);
  assign mf = (field_q == q_field_i);

  // Capture own hits, then fold in the neighbor's flags during the sweep
  always_comb begin
    dup_d = dup_q;
    cnf_d = cnf_q;
    if (ctrl_i.capture) begin
      dup_d = valid_i & ms & mf;
      cnf_d = valid_i & (ms ^ mf);
    end else if (ctrl_i.sweep) begin
      dup_d = dup_q | dup_i;
      cnf_d = cnf_q | cnf_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q <= 1'b0;
      cnf_q <= 1'b0;
    end else begin
      dup_q <= dup_d;
      cnf_q <= cnf_d;
    end
  end

  // Take the neighbor's pair on append
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      star_q  <= prev_star_i;
      field_q <= prev_field_i;
    end
  end

  assign star_o  = star_q;
  assign field_o = field_q;
  assign dup_o   = dup_q;
  assign cnf_o   = cnf_q;

endmodule

// ===== src/pct_ctrl.sv =====
// ----------------------------------------------------------------------------
// pct_ctrl: sequencer of the pair table
// Steps each transfer through compare, flag sweep along the chain and finish.
// ----------------------------------------------------------------------------
module pct_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output pct_pkg::pct_phase_t phase_o
);
  import pct_pkg::*;

  localparam logic [IDX_W-1:0] SweepLast = IDX_W'(CAPACITY - 2);

  pct_state_e       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  // State and sweep counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and phase strobes
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    phase_o = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        phase_o.capture = 1'b1;
        cnt_d           = '0;
        state_d         = ST_SWEEP;
      end
      ST_SWEEP: begin
        phase_o.sweep = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == SweepLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        phase_o.finish = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/pair_correspondence_table_unit.sv =====
// ----------------------------------------------------------------------------
// pair_correspondence_table_unit: table of distinct (star id, field id) pairs
// A row of cells holds the pairs; new pairs enter at cell zero and shift on.
// ----------------------------------------------------------------------------
// Usage:
//   Present star_id_i, field_id_i and start_new_set_i with start_i while
//   busy_o is low; the transfer is taken at that clock edge. A set bit in
//   start_new_set_i empties the table and sets the consistency flag first.
//   Each item passes a compare step in every cell, then a sweep in which
//   the duplicate and conflict flags ripple cell to cell toward cell zero,
//   then a finish step that updates the count and flag and, when the pair
//   is new and the table has room, shifts the pair into the row. busy_o is
//   high through that time. done_o then marks pair_count_o, consistent_o,
//   was_duplicate_o and overflow_o for exactly one cycle; the receiver cannot
//   stall, and a new start may be given in that same cycle. The flag ripple
//   along the cell row sets the item time, so one item is done at a time.
//   Reset empties the table and sets the consistency flag; the stored pairs
//   are not cleared, as only entries below the count are ever compared.
// ----------------------------------------------------------------------------
module pair_correspondence_table_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         start_new_set_i,
  input  logic [pct_pkg::ID_W-1:0]     star_id_i,
  input  logic [pct_pkg::ID_W-1:0]     field_id_i,
  output logic                         done_o,
  output logic [pct_pkg::PCNT_W-1:0]   pair_count_o,
  output logic                         consistent_o,
  output logic                         was_duplicate_o,
  output logic                         overflow_o
);
  import pct_pkg::*;

  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  pct_phase_t      phase;
  pct_cell_ctrl_t  cell_ctrl;
  logic            accept;
  logic            append;
  logic            room;

  logic [ID_W-1:0] q_star_q, q_field_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             flag_q, flag_d;
  logic             done_q;
  logic [PCNT_W-1:0] pcnt_q;
  logic             cons_q, dup_q, ovf_q;

  logic [ID_W-1:0]  star_w  [CAPACITY];
  logic [ID_W-1:0]  field_w [CAPACITY];
  logic             dup_w   [CAPACITY];
  logic             cnf_w   [CAPACITY];

  // Sequencer
  pct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .phase_o (phase)
  );

  assign accept = start_i & ~busy_o;
  assign room   = (count_q != CapCount);
  assign append = phase.finish & ~dup_w[0] & room;

  assign cell_ctrl.capture = phase.capture;
  assign cell_ctrl.sweep   = phase.sweep;
  assign cell_ctrl.shift   = append;

  // Hold the query pair for the whole item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_star_q  <= star_id_i;
      q_field_q <= field_id_i;
    end
  end

  // Row of cells: pairs move right on append, flags move left on sweep
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] Idx = CNT_W'(i);
    logic [ID_W-1:0] prev_star, prev_field;
    logic            next_dup, next_cnf;

    if (i == 0) begin : g_head
      assign prev_star  = q_star_q;
      assign prev_field = q_field_q;
    end else begin : g_body
      assign prev_star  = star_w[i-1];
      assign prev_field = field_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_dup = 1'b0;
      assign next_cnf = 1'b0;
    end else begin : g_link
      assign next_dup = dup_w[i+1];
      assign next_cnf = cnf_w[i+1];
    end

    pct_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .valid_i      (Idx < count_q),
      .q_star_i     (q_star_q),
      .q_field_i    (q_field_q),
      .prev_star_i  (prev_star),
      .prev_field_i (prev_field),
      .star_o       (star_w[i]),
      .field_o      (field_w[i]),
      .dup_i        (next_dup),
      .cnf_i        (next_cnf),
      .dup_o        (dup_w[i]),
      .cnf_o        (cnf_w[i])
    );
  end

  // Update count and consistency: clear on new set, settle at finish
  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    if (accept && start_new_set_i) begin
      count_d = '0;
      flag_d  = 1'b1;
    end else if (phase.finish && !dup_w[0]) begin
      if (cnf_w[0]) begin
        flag_d = 1'b0;
      end
      if (room) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flag_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      flag_q  <= flag_d;
      done_q  <= phase.finish;
    end
  end

  // Register the result at finish
  always_ff @(posedge clk_i) begin
    if (phase.finish) begin
      pcnt_q <= count_d[PCNT_W-1:0];
      cons_q <= flag_d;
      dup_q  <= dup_w[0];
      ovf_q  <= ~dup_w[0] & ~room;
    end
  end

  assign done_o          = done_q;
  assign pair_count_o    = pcnt_q;
  assign consistent_o    = cons_q;
  assign was_duplicate_o = dup_q;
  assign overflow_o      = ovf_q;

endmodule
